>>> src/assert_macros.svh
// Assertion macros used by the checker file of the fade unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_AT(clk_sig, rstn_sig, lbl, prop) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
        else $error("%m: assertion failed");

// Concurrent assertion on the local clk and rst_n.
`define ASSERT_CLK(lbl, prop) `ASSERT_AT(clk, rst_n, lbl, prop)

`endif

>>> src/tafu_pkg.sv
// Shared types and constants of the timed alpha fade unit.
`default_nettype none

package tafu_pkg;

    // Default width of the internal time arithmetic.
    localparam int TIME_BITS_DEF = 32;
    // Duration held after reset, in ms.
    localparam int DURATION_RESET = 1000;
    // Width of the fields on the ports.
    localparam int IN_TIME_W = 32;
    localparam int COLOR_W = 8;
    localparam int OP_W = 2;
    // Half-steps of the scaled divider: two per bit of the 8-bit alpha span.
    localparam int DIV_STEPS = 16;
    localparam int STEP_W = $clog2(DIV_STEPS);

    // Operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 2'd0,
        OP_FADE_IN    = 2'd1,
        OP_FADE_OUT   = 2'd2,
        OP_DEACTIVATE = 2'd3
    } op_t;

    // Controller states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_ELAPSE = 5'b00010,
        ST_DIVIDE = 5'b00100,
        ST_FINISH = 5'b01000,
        ST_WRITE  = 5'b10000
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic capture;
        logic elapse;
        logic div_step;
        logic finish;
        logic load_out;
    } cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        op_t  op;
        logic active;
        logic done;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

>>> src/tafu_ctrl.sv
// Sequencing state machine of the timed alpha fade unit.
`default_nettype none

module tafu_ctrl
    import tafu_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next = ST_ELAPSE;
                end
            end
            ST_ELAPSE:
            begin
                cmd.elapse = 1'b1;
                if (status.op == OP_TICK && status.active)
                begin
                    state_next = ST_DIVIDE;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_DIVIDE:
            begin
                // A finished fade needs no quotient.
                cmd.div_step = !status.done;
                if (status.done || status.div_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/tafu_dp.sv
// Datapath of the timed alpha fade unit: fade state, elapsed time, divider, result.
`default_nettype none

module tafu_dp
    import tafu_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cmd_t                 cmd,
    output status_t                   status,
    input  wire logic [OP_W-1:0]      operation,
    input  wire logic [IN_TIME_W-1:0] time_game,
    input  wire logic [IN_TIME_W-1:0] time_system,
    input  wire logic [COLOR_W-1:0]   color_red,
    input  wire logic [COLOR_W-1:0]   color_green,
    input  wire logic [COLOR_W-1:0]   color_blue,
    input  wire logic [COLOR_W-1:0]   color_alpha,
    input  wire logic [IN_TIME_W-1:0] fade_duration,
    input  wire logic                 use_system_clock,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output logic [COLOR_W-1:0]        out_red,
    output logic [COLOR_W-1:0]        out_green,
    output logic [COLOR_W-1:0]        out_blue,
    output logic [COLOR_W-1:0]        out_alpha,
    output logic                      is_active,
    output logic                      is_ready,
    output logic                      overlay_visible
);

    // Captured input item.
    op_t                  op_reg;
    logic [IN_TIME_W-1:0] tg_reg;
    logic [IN_TIME_W-1:0] ts_reg;
    logic [COLOR_W-1:0]   red_in_reg;
    logic [COLOR_W-1:0]   green_in_reg;
    logic [COLOR_W-1:0]   blue_in_reg;
    logic [COLOR_W-1:0]   alpha_in_reg;
    logic [IN_TIME_W-1:0] dur_in_reg;
    logic                 sel_in_reg;

    // Fade state.
    logic                 active_reg;
    logic                 ready_reg;
    logic [COLOR_W-1:0]   red_reg;
    logic [COLOR_W-1:0]   green_reg;
    logic [COLOR_W-1:0]   blue_reg;
    logic [COLOR_W-1:0]   alpha_reg;
    logic [COLOR_W-1:0]   src_reg;
    logic [COLOR_W-1:0]   tgt_reg;
    logic [TIME_BITS-1:0] dur_reg;
    logic [TIME_BITS-1:0] start_reg;
    logic                 sel_reg;

    // Tick working registers.
    logic [TIME_BITS-1:0] elapsed_reg;
    logic                 done_reg;
    logic                 rising_reg;
    logic [COLOR_W-1:0]   mag_reg;
    logic [TIME_BITS-1:0] rem_reg;
    logic [COLOR_W-1:0]   quo_reg;
    logic [STEP_W-1:0]    step_reg;

    // Result register.
    logic                 out_valid_reg;
    logic [COLOR_W-1:0]   out_red_reg;
    logic [COLOR_W-1:0]   out_green_reg;
    logic [COLOR_W-1:0]   out_blue_reg;
    logic [COLOR_W-1:0]   out_alpha_reg;
    logic                 out_active_reg;
    logic                 out_ready_flag_reg;
    logic                 out_overlay_reg;

    logic [TIME_BITS-1:0] now_ext;
    logic [TIME_BITS-1:0] elapsed_calc;
    logic                 mbit;
    logic                 apply;
    logic [TIME_BITS:0]   sum;
    logic                 sum_ge;
    logic [COLOR_W-1:0]   quo_base;
    logic [COLOR_W-1:0]   quo_adj;
    logic [COLOR_W-1:0]   alpha_calc;

    // Elapsed time on the selected clock, modulo the time width.
    assign now_ext = sel_reg ? TIME_BITS'(ts_reg) : TIME_BITS'(tg_reg);
    assign elapsed_calc = now_ext - start_reg;

    // One half-step of the scaled divider: even steps double, odd steps add elapsed.
    assign mbit = mag_reg[3'd7 - step_reg[STEP_W-1:1]];
    assign apply = !step_reg[0] || mbit;
    assign sum = step_reg[0] ? ({1'b0, rem_reg} + {1'b0, elapsed_reg}) : {rem_reg, 1'b0};
    assign sum_ge = sum >= {1'b0, dur_reg};
    assign quo_base = step_reg[0] ? quo_reg : {quo_reg[COLOR_W-2:0], 1'b0};

    // Falling fades round the quotient up before the subtraction.
    assign quo_adj = quo_reg + COLOR_W'(!rising_reg && rem_reg != '0);
    assign alpha_calc = done_reg ? tgt_reg :
                        (rising_reg ? (src_reg + quo_reg) : (src_reg - quo_adj));

    // Capture of the accepted item.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= op_t'(operation);
            tg_reg       <= time_game;
            ts_reg       <= time_system;
            red_in_reg   <= color_red;
            green_in_reg <= color_green;
            blue_in_reg  <= color_blue;
            alpha_in_reg <= color_alpha;
            dur_in_reg   <= fade_duration;
            sel_in_reg   <= use_system_clock;
        end
    end

    // Fade state updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            ready_reg  <= 1'b0;
            red_reg    <= '0;
            green_reg  <= '0;
            blue_reg   <= '0;
            alpha_reg  <= '0;
            src_reg    <= '0;
            tgt_reg    <= '0;
            dur_reg    <= TIME_BITS'(DURATION_RESET);
            start_reg  <= '0;
            sel_reg    <= 1'b0;
        end
        else if (cmd.elapse)
        begin
            case (op_reg)
                OP_FADE_IN, OP_FADE_OUT:
                begin
                    ready_reg  <= 1'b0;
                    active_reg <= 1'b1;
                    red_reg    <= red_in_reg;
                    green_reg  <= green_in_reg;
                    blue_reg   <= blue_in_reg;
                    if (op_reg == OP_FADE_IN)
                    begin
                        src_reg <= alpha_in_reg;
                        tgt_reg <= '0;
                    end
                    else
                    begin
                        src_reg <= alpha_reg;
                        tgt_reg <= alpha_in_reg;
                    end
                    dur_reg   <= TIME_BITS'(dur_in_reg);
                    sel_reg   <= sel_in_reg;
                    start_reg <= sel_in_reg ? TIME_BITS'(ts_reg) : TIME_BITS'(tg_reg);
                end
                OP_DEACTIVATE:
                begin
                    active_reg <= 1'b0;
                    ready_reg  <= 1'b1;
                end
                default:
                begin
                    // An update tick changes nothing here.
                end
            endcase
        end
        else if (cmd.finish)
        begin
            alpha_reg <= alpha_calc;
            ready_reg <= done_reg;
            if (done_reg && alpha_calc == '0)
            begin
                active_reg <= 1'b0;
            end
        end
    end

    // Elapsed time, completion and divider operands for an update tick.
    always_ff @(posedge clk)
    begin
        if (cmd.elapse)
        begin
            elapsed_reg <= elapsed_calc;
            done_reg    <= elapsed_calc >= dur_reg;
            rising_reg  <= tgt_reg >= src_reg;
            mag_reg     <= (tgt_reg >= src_reg) ? (tgt_reg - src_reg) : (src_reg - tgt_reg);
            rem_reg     <= '0;
            quo_reg     <= '0;
            step_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            step_reg <= step_reg + STEP_W'(1);
            if (apply)
            begin
                if (sum_ge)
                begin
                    rem_reg <= TIME_BITS'(sum - {1'b0, dur_reg});
                    quo_reg <= quo_base + COLOR_W'(1);
                end
                else
                begin
                    rem_reg <= TIME_BITS'(sum);
                    quo_reg <= quo_base;
                end
            end
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_red_reg        <= red_reg;
            out_green_reg      <= green_reg;
            out_blue_reg       <= blue_reg;
            out_alpha_reg      <= alpha_reg;
            out_active_reg     <= active_reg;
            out_ready_flag_reg <= ready_reg;
            out_overlay_reg    <= active_reg && alpha_reg != '0;
        end
    end

    // Status to the controller.
    always_comb
    begin
        status.op       = op_reg;
        status.active   = active_reg;
        status.done     = done_reg;
        status.div_last = step_reg == STEP_W'(DIV_STEPS - 1);
        status.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid       = out_valid_reg;
    assign out_red         = out_red_reg;
    assign out_green       = out_green_reg;
    assign out_blue        = out_blue_reg;
    assign out_alpha       = out_alpha_reg;
    assign is_active       = out_active_reg;
    assign is_ready        = out_ready_flag_reg;
    assign overlay_visible = out_overlay_reg;

endmodule

`default_nettype wire

>>> src/timed_alpha_fade_unit.sv
// Timed alpha fade unit: streams operations in, fade state reports out.
//
// Input transfers carry one operation in s_axis_tuser (update tick, fade in,
// fade out, deactivate) and the times, colour and duration in s_axis_tdata.
// Every input transfer produces exactly one output transfer on m_axis with
// the colour, alpha and flags as they stand after that operation.
// Fade and deactivate operations, and ticks of an inactive unit, form their
// new state and then load the output. An update tick of an active fade forms
// the elapsed time, runs sixteen half-steps of the bit-serial scaled divider
// (two per bit of the alpha span), forms the alpha and then loads the output.
// A tick whose duration has already passed skips the divider steps and goes
// straight on to form the alpha.
// One operation is processed at a time, so s_axis_tready is low from the
// transfer until the result is loaded; the next operation can be taken in the
// cycle after the load, while that result may still wait on m_axis.
// When the receiver stalls, the result holds in the output register and the
// unit stops before loading the following result.
// Reset clears the fade (inactive, alpha 0, duration 1000 ms) and empties the
// output register.
`default_nettype none

module timed_alpha_fade_unit
    import tafu_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [31:0] time_game, [63:32] time_system, [71:64] color_red,
    // [79:72] color_green, [87:80] color_blue, [95:88] color_alpha,
    // [127:96] fade_duration, [128] use_system_clock, rest zero.
    input  wire logic [135:0] s_axis_tdata,
    // [1:0] operation.
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [7:0] out_red, [15:8] out_green, [23:16] out_blue, [31:24] out_alpha,
    // [32] is_active, [33] is_ready, [34] overlay_visible, rest zero.
    output logic [39:0]       m_axis_tdata
);

    cmd_t    cmd;
    status_t status;

    logic [COLOR_W-1:0] out_red;
    logic [COLOR_W-1:0] out_green;
    logic [COLOR_W-1:0] out_blue;
    logic [COLOR_W-1:0] out_alpha;
    logic               is_active;
    logic               is_ready;
    logic               overlay_visible;

    // Sequencer.
    tafu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath with the fade state and the result register.
    tafu_dp #(
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .operation        (s_axis_tuser),
        .time_game        (s_axis_tdata[31:0]),
        .time_system      (s_axis_tdata[63:32]),
        .color_red        (s_axis_tdata[71:64]),
        .color_green      (s_axis_tdata[79:72]),
        .color_blue       (s_axis_tdata[87:80]),
        .color_alpha      (s_axis_tdata[95:88]),
        .fade_duration    (s_axis_tdata[127:96]),
        .use_system_clock (s_axis_tdata[128]),
        .out_ready        (m_axis_tready),
        .out_valid        (m_axis_tvalid),
        .out_red          (out_red),
        .out_green        (out_green),
        .out_blue         (out_blue),
        .out_alpha        (out_alpha),
        .is_active        (is_active),
        .is_ready         (is_ready),
        .overlay_visible  (overlay_visible)
    );

    // Pack the result fields.
    assign m_axis_tdata = {5'b0, overlay_visible, is_ready, is_active,
                           out_alpha, out_blue, out_green, out_red};

endmodule

`default_nettype wire

>>> src/tafu_checker.sv
// Port-level checks of the timed alpha fade unit and their bind.
`default_nettype none
`include "assert_macros.svh"

module tafu_port_checks (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [39:0]  m_axis_tdata
);

    logic overlay_expect;

    // Overlay flag implied by the active flag and the alpha of the offered result.
    assign overlay_expect = m_axis_tdata[32] && m_axis_tdata[31:24] != 8'd0;

    // A stalled result stays offered.
    `ASSERT_CLK(a_out_valid_holds, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)

    // A stalled result keeps its payload.
    `ASSERT_CLK(a_out_data_holds, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))

    // One operation at a time: no input right after a transfer.
    `ASSERT_CLK(a_one_at_a_time, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

    // The overlay is drawn exactly when active with nonzero alpha.
    `ASSERT_CLK(a_overlay_flag, m_axis_tvalid |-> m_axis_tdata[34] == overlay_expect)

endmodule

bind timed_alpha_fade_unit tafu_port_checks u_tafu_port_checks (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
